[rtl/ifsb_pkg.sv]
// shared types, constants and helper functions for the motion frame scaler
`default_nettype none
package ifsb_pkg;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 16;
	localparam int GAIN_W     = 32;
	localparam int VAL_W      = 48;
	localparam int TS_W       = 16;
	localparam int SIDX_W     = 4;
	localparam int CNT_W      = 5;
	localparam int POS_W      = 5;
	localparam int SLOT_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_SLOTS  = 9;

	localparam logic [BYTE_W-1:0] BYTE_DATA = 8'h53;
	localparam logic [BYTE_W-1:0] BYTE_BIAS = 8'h42;

	localparam logic [POS_W-1:0] REC_LEN_PLAIN = 5'd12;
	localparam logic [POS_W-1:0] REC_LEN_MAG   = 5'd18;

	localparam logic [CNT_W-1:0]  SENSOR_COUNT_RST = 5'd1;
	localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST   = 32'd2571764;
	localparam logic [GAIN_W-1:0] GYRO_GAIN_RST    = 32'd572224;
	localparam logic [GAIN_W-1:0] MAG_GAIN_RST     = 32'd644;

	// raw word order inside a record
	localparam logic [SLOT_W-1:0] WORD_GYRO_FIRST = 4'd3;
	localparam logic [SLOT_W-1:0] WORD_MAG_RAW_X  = 4'd6;
	localparam logic [SLOT_W-1:0] WORD_MAG_RAW_Y  = 4'd7;
	localparam logic [SLOT_W-1:0] WORD_MAG_RAW_Z  = 4'd8;

	// result slot order
	localparam logic [SLOT_W-1:0] SLOT_ACCEL_X = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_ACCEL_Y = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_ACCEL_Z = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_GYRO_X  = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_GYRO_Y  = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_GYRO_Z  = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_MAG_X   = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_MAG_Y   = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_MAG_Z   = 4'd8;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_HEADER,
		KIND_DATA,
		KIND_BIAS
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENSOR_COUNT = 3'd0,
		CFG_USE_MAG      = 3'd1,
		CFG_ACCEL_GAIN   = 3'd2,
		CFG_GYRO_GAIN    = 3'd3,
		CFG_MAG_GAIN     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GAIN_ACCEL,
		GAIN_GYRO,
		GAIN_MAG
	} gain_sel_t;

	typedef struct packed {
		logic [CNT_W-1:0]  sensor_count;
		logic              use_mag;
		logic [GAIN_W-1:0] accel_gain;
		logic [GAIN_W-1:0] gyro_gain;
		logic [GAIN_W-1:0] mag_gain;
	} cfg_t;

	// one parsed byte that completes a word and/or a record
	typedef struct packed {
		logic              has_word;
		logic [WORD_W-1:0] word;
		logic              negate;
		gain_sel_t         gain_sel;
		logic [SLOT_W-1:0] slot;
		logic              is_bias;
		logic              bias_valid;
		logic              emit;
		logic              last;
		logic [SIDX_W-1:0] sensor_index;
		logic [TS_W-1:0]   timestamp;
	} item_t;

	// mag X and Y trade places, everything else keeps its order
	function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] word_idx);
		priority if (word_idx < WORD_MAG_RAW_X) begin
			slot_of = word_idx;
		end else if (word_idx == WORD_MAG_RAW_X) begin
			slot_of = SLOT_MAG_Y;
		end else if (word_idx == WORD_MAG_RAW_Y) begin
			slot_of = SLOT_MAG_X;
		end else begin
			slot_of = SLOT_MAG_Z;
		end
	endfunction

	function automatic gain_sel_t gain_of(input logic [SLOT_W-1:0] word_idx);
		priority if (word_idx < WORD_GYRO_FIRST) begin
			gain_of = GAIN_ACCEL;
		end else if (word_idx < WORD_MAG_RAW_X) begin
			gain_of = GAIN_GYRO;
		end else begin
			gain_of = GAIN_MAG;
		end
	endfunction

endpackage
`default_nettype wire

[rtl/ifsb_byte_if.sv]
// byte stream channel: valid/ready with one frame byte per transaction
`default_nettype none
interface ifsb_byte_if;
	logic                         valid;
	logic                         ready;
	logic [ifsb_pkg::BYTE_W-1:0]  data_byte;
	logic                         start_of_frame;

	modport source(output valid, output data_byte, output start_of_frame, input ready);
	modport sink(input valid, input data_byte, input start_of_frame, output ready);
endinterface
`default_nettype wire

[rtl/ifsb_rec_if.sv]
// sensor record channel: valid/ready with one scaled record per transaction
`default_nettype none
interface ifsb_rec_if;
	logic                               valid;
	logic                               ready;
	logic [ifsb_pkg::SIDX_W-1:0]        sensor_index;
	logic [ifsb_pkg::TS_W-1:0]          timestamp;
	logic signed [ifsb_pkg::VAL_W-1:0]  accel_x;
	logic signed [ifsb_pkg::VAL_W-1:0]  accel_y;
	logic signed [ifsb_pkg::VAL_W-1:0]  accel_z;
	logic signed [ifsb_pkg::VAL_W-1:0]  gyro_x;
	logic signed [ifsb_pkg::VAL_W-1:0]  gyro_y;
	logic signed [ifsb_pkg::VAL_W-1:0]  gyro_z;
	logic signed [ifsb_pkg::VAL_W-1:0]  mag_x;
	logic signed [ifsb_pkg::VAL_W-1:0]  mag_y;
	logic signed [ifsb_pkg::VAL_W-1:0]  mag_z;
	logic                               last_sensor;

	modport source(
		output valid, output sensor_index, output timestamp,
		output accel_x, output accel_y, output accel_z,
		output gyro_x, output gyro_y, output gyro_z,
		output mag_x, output mag_y, output mag_z, output last_sensor,
		input ready
	);
	modport sink(
		input valid, input sensor_index, input timestamp,
		input accel_x, input accel_y, input accel_z,
		input gyro_x, input gyro_y, input gyro_z,
		input mag_x, input mag_y, input mag_z, input last_sensor,
		output ready
	);
endinterface
`default_nettype wire

[rtl/ifsb_cfg_regs.sv]
// configuration register file written through the plain write port
`default_nettype none
module ifsb_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ifsb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ifsb_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ifsb_pkg::cfg_t                           cfg
);

	ifsb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_count <= ifsb_pkg::SENSOR_COUNT_RST;
			cfg_q.use_mag      <= 1'b0;
			cfg_q.accel_gain   <= ifsb_pkg::ACCEL_GAIN_RST;
			cfg_q.gyro_gain    <= ifsb_pkg::GYRO_GAIN_RST;
			cfg_q.mag_gain     <= ifsb_pkg::MAG_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ifsb_pkg::CFG_SENSOR_COUNT: begin
					cfg_q.sensor_count <= cfg_data[ifsb_pkg::CNT_W-1:0];
				end
				ifsb_pkg::CFG_USE_MAG: begin
					cfg_q.use_mag <= cfg_data[0];
				end
				ifsb_pkg::CFG_ACCEL_GAIN: begin
					cfg_q.accel_gain <= cfg_data[ifsb_pkg::GAIN_W-1:0];
				end
				ifsb_pkg::CFG_GYRO_GAIN: begin
					cfg_q.gyro_gain <= cfg_data[ifsb_pkg::GAIN_W-1:0];
				end
				ifsb_pkg::CFG_MAG_GAIN: begin
					cfg_q.mag_gain <= cfg_data[ifsb_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/ifsb_parser.sv]
// frame parser: tracks frame kind, byte position and sensor, assembles words
`default_nettype none
module ifsb_parser #(
	parameter int MAX_SENSORS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  ifsb_pkg::cfg_t                          cfg,
	input  wire logic                               take,
	input  wire logic [ifsb_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic                               start_of_frame,
	output logic                                    item_valid,
	output ifsb_pkg::item_t                         item,
	output logic [((MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1)-1:0] item_sensor
);

	localparam int SW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int LCW = $clog2(MAX_SENSORS + 32);

	ifsb_pkg::kind_t                  kind_q, kind_d;
	logic [ifsb_pkg::POS_W-1:0]       pos_q, pos_d;
	logic [SW-1:0]                    sensor_q, sensor_d;
	logic [ifsb_pkg::BYTE_W-1:0]      hold_q, hold_d;
	logic [ifsb_pkg::TS_W-1:0]        time_q, time_d;
	logic                             bias_valid_q, bias_valid_d;

	logic [ifsb_pkg::POS_W-1:0]       rec_len;
	logic [ifsb_pkg::POS_W-1:0]       pos_inc;
	logic [LCW-1:0]                   count_ext;
	logic [LCW-1:0]                   live_count;
	logic                             last;
	logic                             rec_end;
	logic [ifsb_pkg::SLOT_W-1:0]      word_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= ifsb_pkg::KIND_IDLE;
			pos_q        <= '0;
			sensor_q     <= '0;
			hold_q       <= '0;
			time_q       <= '0;
			bias_valid_q <= 1'b0;
		end else begin
			kind_q       <= kind_d;
			pos_q        <= pos_d;
			sensor_q     <= sensor_d;
			hold_q       <= hold_d;
			time_q       <= time_d;
			bias_valid_q <= bias_valid_d;
		end
	end

	// sensor count zero acts as one, large counts clamp to the table size
	always_comb begin
		count_ext = LCW'(cfg.sensor_count);
		priority if (cfg.sensor_count == '0) begin
			live_count = LCW'(1);
		end else if (count_ext > LCW'(MAX_SENSORS)) begin
			live_count = LCW'(MAX_SENSORS);
		end else begin
			live_count = count_ext;
		end
	end

	assign rec_len  = cfg.use_mag ? ifsb_pkg::REC_LEN_MAG : ifsb_pkg::REC_LEN_PLAIN;
	assign pos_inc  = pos_q + ifsb_pkg::POS_W'(1);
	assign last     = (LCW'(sensor_q) + LCW'(1)) >= live_count;
	assign word_idx = pos_q[ifsb_pkg::POS_W-1:1];

	always_comb begin
		kind_d       = kind_q;
		pos_d        = pos_q;
		sensor_d     = sensor_q;
		hold_d       = hold_q;
		time_d       = time_q;
		bias_valid_d = bias_valid_q;
		rec_end      = 1'b0;
		item_valid   = 1'b0;
		if (take) begin
			if (start_of_frame) begin
				pos_d    = '0;
				sensor_d = '0;
				priority if (data_byte == ifsb_pkg::BYTE_DATA) begin
					kind_d = ifsb_pkg::KIND_HEADER;
				end else if (data_byte == ifsb_pkg::BYTE_BIAS) begin
					kind_d = ifsb_pkg::KIND_BIAS;
				end else begin
					kind_d = ifsb_pkg::KIND_IDLE;
				end
			end else begin
				unique case (kind_q)
					ifsb_pkg::KIND_IDLE: begin
					end
					ifsb_pkg::KIND_HEADER: begin
						if (pos_q == '0) begin
							hold_d = data_byte;
							pos_d  = ifsb_pkg::POS_W'(1);
						end else begin
							time_d = {hold_q, data_byte};
							pos_d  = '0;
							kind_d = ifsb_pkg::KIND_DATA;
						end
					end
					ifsb_pkg::KIND_DATA, ifsb_pkg::KIND_BIAS: begin
						if (!pos_q[0]) begin
							hold_d = data_byte;
						end
						pos_d = pos_inc;
						if (pos_inc >= rec_len) begin
							rec_end = 1'b1;
							pos_d   = '0;
							if (last) begin
								kind_d = ifsb_pkg::KIND_IDLE;
								if (kind_q == ifsb_pkg::KIND_BIAS) begin
									bias_valid_d = 1'b1;
								end
							end else begin
								sensor_d = sensor_q + SW'(1);
							end
						end
						// a record can end on a high byte if the length shrank mid-record
						item_valid = pos_q[0] || rec_end;
					end
				endcase
			end
		end
	end

	always_comb begin
		item.has_word     = pos_q[0];
		item.word         = {hold_q, data_byte};
		item.negate       = word_idx >= ifsb_pkg::WORD_MAG_RAW_Z;
		item.gain_sel     = ifsb_pkg::gain_of(word_idx);
		item.slot         = ifsb_pkg::slot_of(word_idx);
		item.is_bias      = kind_q == ifsb_pkg::KIND_BIAS;
		item.bias_valid   = bias_valid_q;
		item.emit         = rec_end && (kind_q == ifsb_pkg::KIND_DATA);
		item.last         = last;
		item.sensor_index = ifsb_pkg::SIDX_W'(sensor_q);
		item.timestamp    = time_q;
	end

	assign item_sensor = sensor_q;

endmodule
`default_nettype wire

[rtl/ifsb_scale.sv]
// scaling pipeline: gain multiply, bias store and saturating bias subtract
`default_nettype none
module ifsb_scale #(
	parameter int MAX_SENSORS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  ifsb_pkg::cfg_t                            cfg,
	input  wire logic                                 item_valid,
	input  ifsb_pkg::item_t                           item,
	input  wire logic [((MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1)-1:0] item_sensor,
	output logic                                      valid_s2,
	output ifsb_pkg::item_t                           item_s2,
	output logic signed [ifsb_pkg::VAL_W-1:0]         result_val
);

	localparam int DEPTH = MAX_SENSORS * ifsb_pkg::NUM_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int OPW   = ifsb_pkg::WORD_W + 1;
	localparam int PW    = OPW + ifsb_pkg::GAIN_W + 1;
	localparam int DW    = ifsb_pkg::VAL_W + 1;

	logic                              valid_s1;
	ifsb_pkg::item_t                   item_s1;
	logic [AW-1:0]                     addr_s1;
	logic signed [OPW-1:0]             op_s1;
	logic [ifsb_pkg::GAIN_W-1:0]       gain_s1;

	logic [AW-1:0]                     addr_s2;
	logic signed [ifsb_pkg::VAL_W-1:0] prod_s2;
	logic signed [ifsb_pkg::VAL_W-1:0] bias_rd_q;

	logic signed [ifsb_pkg::VAL_W-1:0] bias_mem [DEPTH];

	logic [AW-1:0]                     addr;
	logic signed [OPW-1:0]             op_raw;
	logic [ifsb_pkg::GAIN_W-1:0]       gain_pick;
	logic signed [PW-1:0]              prod_full;
	logic signed [DW-1:0]              diff;
	logic signed [ifsb_pkg::VAL_W-1:0] diff_sat;

	assign addr   = AW'(item_sensor) * AW'(ifsb_pkg::NUM_SLOTS) + AW'(item.slot);
	// negate before the multiply so the Z flip costs no extra wide adder
	assign op_raw = item.negate ? -$signed({item.word[ifsb_pkg::WORD_W-1], item.word})
	                            : $signed({item.word[ifsb_pkg::WORD_W-1], item.word});

	always_comb begin
		unique case (item.gain_sel)
			ifsb_pkg::GAIN_ACCEL: gain_pick = cfg.accel_gain;
			ifsb_pkg::GAIN_GYRO:  gain_pick = cfg.gyro_gain;
			default:              gain_pick = cfg.mag_gain;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_valid) begin
			item_s1 <= item;
			addr_s1 <= addr;
			op_s1   <= op_raw;
			gain_s1 <= gain_pick;
		end
		if (adv && valid_s1) begin
			item_s2 <= item_s1;
			addr_s2 <= addr_s1;
			prod_s2 <= prod_full[ifsb_pkg::VAL_W-1:0];
		end
	end

	assign prod_full = op_s1 * $signed({1'b0, gain_s1});

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && !item_s1.is_bias) begin
			bias_rd_q <= bias_mem[addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && item_s2.is_bias && item_s2.has_word) begin
			bias_mem[addr_s2] <= prod_s2;
		end
	end

	assign diff = {prod_s2[ifsb_pkg::VAL_W-1], prod_s2}
	            - {bias_rd_q[ifsb_pkg::VAL_W-1], bias_rd_q};

	always_comb begin
		if (diff[DW-1] != diff[DW-2]) begin
			diff_sat = diff[DW-1] ? {1'b1, {(ifsb_pkg::VAL_W-1){1'b0}}}
			                      : {1'b0, {(ifsb_pkg::VAL_W-1){1'b1}}};
		end else begin
			diff_sat = diff[ifsb_pkg::VAL_W-1:0];
		end
	end

	assign result_val = item_s2.bias_valid ? diff_sat : prod_s2;

endmodule
`default_nettype wire

[rtl/imu_frame_scale_bias_core.sv]
// Motion frame scaler: one byte per cycle in, one scaled record per sensor out.
// A record's closing word passes stages s1 and s2, then loads the output register.
// Throughput: one byte per cycle; input holds only while a finished record waits
// and the next record is already complete in the second stage.
// Reset clears parser state and loads default configuration; the bias store is
// not cleared and holds valid data only once a bias frame has been written.
`default_nettype none
module imu_frame_scale_bias_core #(
	parameter int MAX_SENSORS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ifsb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ifsb_pkg::CFG_DATA_W-1:0]    cfg_data,
	ifsb_byte_if.sink                               bytes,
	ifsb_rec_if.source                              records
);

	localparam int SW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

	ifsb_pkg::cfg_t                    cfg;
	logic                              adv;
	logic                              take;
	logic                              item_valid;
	ifsb_pkg::item_t                   item;
	logic [SW-1:0]                     item_sensor;
	logic                              valid_s2;
	ifsb_pkg::item_t                   item_s2;
	logic signed [ifsb_pkg::VAL_W-1:0] result_val;
	logic                              load_out;

	logic signed [ifsb_pkg::VAL_W-1:0] record_q [ifsb_pkg::NUM_SLOTS];
	logic signed [ifsb_pkg::VAL_W-1:0] merged [ifsb_pkg::NUM_SLOTS];
	logic signed [ifsb_pkg::VAL_W-1:0] out_val_q [ifsb_pkg::NUM_SLOTS];
	logic                              out_valid_q;
	logic [ifsb_pkg::SIDX_W-1:0]       out_sidx_q;
	logic [ifsb_pkg::TS_W-1:0]         out_ts_q;
	logic                              out_last_q;

	ifsb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stall only when a second record is ready while the output still waits
	assign adv          = !(valid_s2 && item_s2.emit && out_valid_q && !records.ready);
	assign bytes.ready  = adv;
	assign take         = bytes.valid && adv;
	assign load_out     = adv && valid_s2 && item_s2.emit;

	ifsb_parser #(
		.MAX_SENSORS (MAX_SENSORS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.take           (take),
		.data_byte      (bytes.data_byte),
		.start_of_frame (bytes.start_of_frame),
		.item_valid     (item_valid),
		.item           (item),
		.item_sensor    (item_sensor)
	);

	ifsb_scale #(
		.MAX_SENSORS (MAX_SENSORS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg),
		.item_valid  (item_valid),
		.item        (item),
		.item_sensor (item_sensor),
		.valid_s2    (valid_s2),
		.item_s2     (item_s2),
		.result_val  (result_val)
	);

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && item_s2.has_word && !item_s2.is_bias) begin
			record_q[item_s2.slot] <= result_val;
		end
	end

	// the closing word of a record goes straight to the output
	always_comb begin
		for (int j = 0; j < ifsb_pkg::NUM_SLOTS; j++) begin
			if (item_s2.has_word && (item_s2.slot == ifsb_pkg::SLOT_W'(j))) begin
				merged[j] = result_val;
			end else begin
				merged[j] = record_q[j];
			end
			if ((ifsb_pkg::SLOT_W'(j) >= ifsb_pkg::SLOT_MAG_X) && !cfg.use_mag) begin
				merged[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_val_q  <= merged;
			out_sidx_q <= item_s2.sensor_index;
			out_ts_q   <= item_s2.timestamp;
			out_last_q <= item_s2.last;
		end
	end

	assign records.valid        = out_valid_q;
	assign records.sensor_index = out_sidx_q;
	assign records.timestamp    = out_ts_q;
	assign records.accel_x      = out_val_q[ifsb_pkg::SLOT_ACCEL_X];
	assign records.accel_y      = out_val_q[ifsb_pkg::SLOT_ACCEL_Y];
	assign records.accel_z      = out_val_q[ifsb_pkg::SLOT_ACCEL_Z];
	assign records.gyro_x       = out_val_q[ifsb_pkg::SLOT_GYRO_X];
	assign records.gyro_y       = out_val_q[ifsb_pkg::SLOT_GYRO_Y];
	assign records.gyro_z       = out_val_q[ifsb_pkg::SLOT_GYRO_Z];
	assign records.mag_x        = out_val_q[ifsb_pkg::SLOT_MAG_X];
	assign records.mag_y        = out_val_q[ifsb_pkg::SLOT_MAG_Y];
	assign records.mag_z        = out_val_q[ifsb_pkg::SLOT_MAG_Z];
	assign records.last_sensor  = out_last_q;

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> (records.valid && !records.ready))
		else $error("byte input stalled without a waiting record");

	a_record_from_pipeline: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(records.valid) |-> $past(valid_s2 && item_s2.emit))
		else $error("record transaction raised without a completed record");

	a_mag_zero_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(records.valid && !cfg.use_mag) |->
		(records.mag_x == '0 && records.mag_y == '0 && records.mag_z == '0))
		else $error("magnetometer fields nonzero while magnetometer is off");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench for imu_frame_scale_bias_core: byte-level frame stimulus with a scoreboard
`timescale 1ns / 100ps
module tb_top;
	import ifsb_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int MAX_SENSORS    = 16;
	localparam int MOTION_AXES    = 6;
	localparam int FIELD_AXES     = 3;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_BYTES    = 192;
	localparam int RANDOM_PHASES  = 6;

	localparam int PAT_RANDOM    = 0;
	localparam int PAT_MIN_FIRST = 1; // sensor 0 all most-negative words, sensor 1 all most-positive
	localparam int PAT_MAX_FIRST = 2;

	localparam logic [BYTE_W-1:0] BYTE_OTHER = 8'h58;
	localparam logic [BYTE_W-1:0] BYTE_PARK  = 8'h00;

	localparam longint VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              sof;
	} byte_xfer_t;

	typedef struct packed {
		logic [SIDX_W-1:0]                sensor_index;
		logic [TS_W-1:0]                  timestamp;
		logic [NUM_SLOTS-1:0][VAL_W-1:0]  vals;
		logic                             last_sensor;
	} sensor_rec_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ifsb_byte_if byte_ch();
	ifsb_rec_if  rec_ch();

	imu_frame_scale_bias_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (byte_ch),
		.records   (rec_ch)
	);

	// predictor copy of the configuration
	logic [CNT_W-1:0]  cfg_count      = SENSOR_COUNT_RST;
	logic              cfg_mag        = 1'b0;
	logic [GAIN_W-1:0] cfg_accel_gain = ACCEL_GAIN_RST;
	logic [GAIN_W-1:0] cfg_gyro_gain  = GYRO_GAIN_RST;
	logic [GAIN_W-1:0] cfg_mag_gain   = MAG_GAIN_RST;

	// predictor copy of the parser and bias store
	kind_t             psr_kind   = KIND_IDLE;
	int                psr_pos    = 0;
	int                psr_sensor = 0;
	logic [BYTE_W-1:0] psr_hold   = '0;
	logic [TS_W-1:0]   psr_time   = '0;
	longint            rec_vals [NUM_SLOTS];
	longint            motion_bias [MAX_SENSORS*MOTION_AXES];
	longint            field_bias [MAX_SENSORS*FIELD_AXES];
	bit                bias_loaded = 1'b0;

	byte_xfer_t  bytes_to_send [$];
	sensor_rec_t records_due [$];
	int          bytes_pending = 0;
	bit          byte_taken = 1'b0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatches = 0;
	int          cycle_count = 0;

	string slot_names [NUM_SLOTS] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y",
		"gyro_z", "mag_x", "mag_y", "mag_z"};

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("imu_frame_scale_bias_core: mismatch");
			$finish;
		end
	end

	// advance the parser model by one byte, queue a record when one completes
	task automatic scale_frame_byte(input logic [BYTE_W-1:0] b, input logic sof);
		logic [POS_W-1:0]   rec_len;
		logic signed [WORD_W-1:0] word;
		longint             v;
		longint             gain;
		longint             bias;
		int                 word_idx;
		int                 slot;
		int                 sensor;
		int                 eff_count;
		bit                 last;
		sensor_rec_t        rec;
		rec_len = cfg_mag ? REC_LEN_MAG : REC_LEN_PLAIN;
		if (sof) begin
			psr_pos = 0;
			psr_sensor = 0;
			if (b == BYTE_DATA) psr_kind = KIND_HEADER;
			else if (b == BYTE_BIAS) psr_kind = KIND_BIAS;
			else psr_kind = KIND_IDLE;
			return;
		end
		if (psr_kind == KIND_IDLE) return;
		if (psr_kind == KIND_HEADER) begin
			if (psr_pos == 0) begin
				psr_hold = b;
				psr_pos = 1;
			end else begin
				psr_time = {psr_hold, b};
				psr_pos = 0;
				psr_kind = KIND_DATA;
			end
			return;
		end

		if (psr_pos % 2 == 0) begin
			psr_hold = b;
		end else begin
			word_idx = psr_pos / 2;
			word = {psr_hold, b};
			if (word_idx < WORD_GYRO_FIRST) gain = cfg_accel_gain;
			else if (word_idx < WORD_MAG_RAW_X) gain = cfg_gyro_gain;
			else gain = cfg_mag_gain;
			v = longint'(word) * gain;
			// mag axes: raw X and Y trade places, Z flips sign
			if (word_idx == WORD_MAG_RAW_X) begin
				slot = SLOT_MAG_Y;
			end else if (word_idx == WORD_MAG_RAW_Y) begin
				slot = SLOT_MAG_X;
			end else if (word_idx == WORD_MAG_RAW_Z) begin
				slot = SLOT_MAG_Z;
				v = -v;
			end else begin
				slot = word_idx;
			end
			sensor = psr_sensor % MAX_SENSORS;
			if (psr_kind == KIND_BIAS) begin
				if (slot < SLOT_MAG_X) motion_bias[sensor*MOTION_AXES + slot] = v;
				else field_bias[sensor*FIELD_AXES + slot - SLOT_MAG_X] = v;
			end else begin
				if (bias_loaded) begin
					bias = (slot < SLOT_MAG_X) ? motion_bias[sensor*MOTION_AXES + slot]
						: field_bias[sensor*FIELD_AXES + slot - SLOT_MAG_X];
					v = v - bias;
					if (v > VAL_MAX) v = VAL_MAX;
					if (v < VAL_MIN) v = VAL_MIN;
				end
				rec_vals[slot] = v;
			end
		end
		psr_pos = (psr_pos + 1) % 32;
		if (psr_pos < rec_len) return;

		psr_pos = 0;
		eff_count = (cfg_count == 0) ? 1 : (cfg_count > MAX_SENSORS) ? MAX_SENSORS : cfg_count;
		last = (psr_sensor + 1) >= eff_count;
		if (psr_kind == KIND_DATA) begin
			rec.sensor_index = psr_sensor[SIDX_W-1:0];
			rec.timestamp = psr_time;
			for (int j = 0; j < NUM_SLOTS; j++)
				rec.vals[j] = (j >= SLOT_MAG_X && !cfg_mag) ? '0 : rec_vals[j][VAL_W-1:0];
			rec.last_sensor = last;
			records_due.push_back(rec);
		end else if (last) begin
			bias_loaded = 1'b1;
		end
		if (last) psr_kind = KIND_IDLE;
		else psr_sensor++;
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			scale_frame_byte(byte_ch.data_byte, byte_ch.start_of_frame);
			bytes_pending--;
			byte_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : drive_bytes
		byte_xfer_t nxt;
		if (!byte_ch.valid || byte_taken) begin
			if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = bytes_to_send.pop_front();
				byte_ch.valid <= 1'b1;
				byte_ch.data_byte <= nxt.data_byte;
				byte_ch.start_of_frame <= nxt.sof;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
		byte_taken = 1'b0;
	end

	// record monitor
	always @(negedge clk) begin
		rec_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_records
		logic [NUM_SLOTS-1:0][VAL_W-1:0] got;
		sensor_rec_t want;
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			got[SLOT_ACCEL_X] = rec_ch.accel_x;
			got[SLOT_ACCEL_Y] = rec_ch.accel_y;
			got[SLOT_ACCEL_Z] = rec_ch.accel_z;
			got[SLOT_GYRO_X]  = rec_ch.gyro_x;
			got[SLOT_GYRO_Y]  = rec_ch.gyro_y;
			got[SLOT_GYRO_Z]  = rec_ch.gyro_z;
			got[SLOT_MAG_X]   = rec_ch.mag_x;
			got[SLOT_MAG_Y]   = rec_ch.mag_y;
			got[SLOT_MAG_Z]   = rec_ch.mag_z;
			if (records_due.size() == 0) begin
				$error("record for sensor %0d arrived with nothing outstanding",
					rec_ch.sensor_index);
				mismatches++;
			end else begin
				want = records_due.pop_front();
				if (rec_ch.sensor_index !== want.sensor_index) begin
					$error("sensor_index: expected %0d, got %0d", want.sensor_index,
						rec_ch.sensor_index);
					mismatches++;
				end
				if (rec_ch.timestamp !== want.timestamp) begin
					$error("timestamp: expected %0d, got %0d", want.timestamp, rec_ch.timestamp);
					mismatches++;
				end
				for (int j = 0; j < NUM_SLOTS; j++) begin
					if (got[j] !== want.vals[j]) begin
						$error("%s: expected %0d, got %0d", slot_names[j],
							$signed(want.vals[j]), $signed(got[j]));
						mismatches++;
					end
				end
				if (rec_ch.last_sensor !== want.last_sensor) begin
					$error("last_sensor: expected %0d, got %0d", want.last_sensor,
						rec_ch.last_sensor);
					mismatches++;
				end
			end
		end
	end

	task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic sof);
		bytes_to_send.push_back('{data_byte: b, sof: sof});
		bytes_pending++;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: pick_word = 16'h8000;
			1: pick_word = 16'h7FFF;
			2: pick_word = 16'h0000;
			3: pick_word = 16'hFFFF;
			default: pick_word = WORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] dflt);
		case ($urandom_range(0, 5))
			0: pick_gain = '0;
			1: pick_gain = '1;
			2: pick_gain = dflt;
			default: pick_gain = $urandom;
		endcase
	endfunction

	// type byte, then body; keep < 0 sends the whole body, else only its first keep bytes
	task automatic queue_frame(input logic [BYTE_W-1:0] type_byte, input int sensors,
			input int words_per_rec, input int keep, input int pattern, output int queued);
		logic [BYTE_W-1:0] body [$];
		logic [WORD_W-1:0] w;
		int sensor;
		if (type_byte == BYTE_DATA) begin
			w = pick_word();
			body.push_back(w[15:8]);
			body.push_back(w[7:0]);
		end
		for (int k = 0; k < sensors * words_per_rec; k++) begin
			sensor = k / words_per_rec;
			w = pick_word();
			if (pattern == PAT_MIN_FIRST && sensor == 0) w = 16'h8000;
			if (pattern == PAT_MIN_FIRST && sensor == 1) w = 16'h7FFF;
			if (pattern == PAT_MAX_FIRST && sensor == 0) w = 16'h7FFF;
			if (pattern == PAT_MAX_FIRST && sensor == 1) w = 16'h8000;
			body.push_back(w[15:8]);
			body.push_back(w[7:0]);
		end
		queue_byte(type_byte, 1'b1);
		queued = 0;
		for (int i = 0; i < body.size() && (keep < 0 || i < keep); i++) begin
			queue_byte(body[i], 1'b0);
			queued++;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SENSOR_COUNT: cfg_count = val[CNT_W-1:0];
			CFG_USE_MAG:      cfg_mag = val[0];
			CFG_ACCEL_GAIN:   cfg_accel_gain = val;
			CFG_GYRO_GAIN:    cfg_gyro_gain = val;
			CFG_MAG_GAIN:     cfg_mag_gain = val;
			default: ;
		endcase
	endtask

	task automatic write_gains(input logic [GAIN_W-1:0] a, input logic [GAIN_W-1:0] g,
			input logic [GAIN_W-1:0] m);
		write_reg(CFG_ACCEL_GAIN, a);
		write_reg(CFG_GYRO_GAIN, g);
		write_reg(CFG_MAG_GAIN, m);
	endtask

	// also covers the parser finishing a frame that produces no record
	task automatic wait_drained();
		while (bytes_pending != 0 || records_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_pacing(input int ph);
		case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endtask

	initial begin : stimulus
		int n;
		int used;
		int pick;
		int eff;
		int wpr;
		int keep;
		logic [CNT_W-1:0] cnt;
		logic [BYTE_W-1:0] type_byte;
		foreach (rec_vals[i]) rec_vals[i] = 0;
		foreach (motion_bias[i]) motion_bias[i] = 0;
		foreach (field_bias[i]) field_bias[i] = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SENSOR_COUNT;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.start_of_frame = 1'b0;
		rec_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, default configuration, no bias loaded yet
		set_pacing(3);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(BYTE_DATA, 1'b0); // not a frame start, still ignored
		queue_frame(BYTE_DATA, 1, MOTION_AXES, -1, PAT_MIN_FIRST, n);
		queue_frame(BYTE_DATA, 1, MOTION_AXES, -1, PAT_MAX_FIRST, n);
		queue_frame(BYTE_OTHER, 1, MOTION_AXES, 5, PAT_RANDOM, n);
		queue_frame(BYTE_DATA, 1, MOTION_AXES, 7, PAT_RANDOM, n);
		queue_frame(BYTE_BIAS, 1, MOTION_AXES, 9, PAT_RANDOM, n); // abandoned, bias stays off
		queue_frame(BYTE_DATA, 1, MOTION_AXES, -1, PAT_RANDOM, n);
		wait_drained();

		write_reg(CFG_SENSOR_COUNT, 0); // acts as one sensor
		write_reg(CFG_USE_MAG, 1);
		write_gains('1, '1, '1);
		queue_frame(BYTE_DATA, 1, NUM_SLOTS, -1, PAT_MIN_FIRST, n);
		wait_drained();
		write_gains('0, '0, '0);
		queue_frame(BYTE_DATA, 1, NUM_SLOTS, -1, PAT_RANDOM, n);
		wait_drained();

		// load the whole bias store so later reads always hit written entries
		write_reg(CFG_SENSOR_COUNT, MAX_SENSORS);
		write_gains('1, '1, '1);
		queue_frame(BYTE_BIAS, MAX_SENSORS, NUM_SLOTS, -1, PAT_MIN_FIRST, n);
		wait_drained();
		// subtraction saturates at both ends
		write_reg(CFG_SENSOR_COUNT, 2);
		queue_frame(BYTE_DATA, 2, NUM_SLOTS, -1, PAT_MAX_FIRST, n);
		queue_frame(BYTE_DATA, 2, NUM_SLOTS, -1, PAT_MIN_FIRST, n);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_pacing(ph);
			if (ph == 0) cnt = 31;
			else if (ph == 1) cnt = 0;
			else begin
				pick = $urandom_range(0, 9);
				if (pick == 0) cnt = 0;
				else if (pick == 1) cnt = MAX_SENSORS;
				else if (pick == 2) cnt = $urandom_range(MAX_SENSORS + 1, 31);
				else cnt = $urandom_range(1, 4);
			end
			write_reg(CFG_SENSOR_COUNT, cnt);
			write_reg(CFG_USE_MAG, $urandom_range(0, 1));
			write_gains(pick_gain(ACCEL_GAIN_RST), pick_gain(GYRO_GAIN_RST),
				pick_gain(MAG_GAIN_RST));
			eff = (cnt == 0) ? 1 : (cnt > MAX_SENSORS) ? MAX_SENSORS : cnt;
			wpr = cfg_mag ? NUM_SLOTS : MOTION_AXES;
			used = 0;
			while (used < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					queue_frame(BYTE_DATA, eff, wpr, -1, PAT_RANDOM, n);
					used += n;
				end else if (pick < 82) begin
					queue_frame(BYTE_BIAS, eff, wpr, -1, PAT_RANDOM, n);
					used += n;
				end else if (pick < 90) begin
					// broken frame, cut short by whatever follows
					type_byte = $urandom_range(0, 1) ? BYTE_DATA : BYTE_BIAS;
					keep = $urandom_range(0, 2 * eff * wpr);
					queue_frame(type_byte, eff, wpr, keep, PAT_RANDOM, n);
					used += n;
				end else if (pick < 95) begin
					do type_byte = $urandom_range(0, 255);
					while (type_byte == BYTE_DATA || type_byte == BYTE_BIAS);
					queue_frame(type_byte, 1, MOTION_AXES, $urandom_range(0, 20), PAT_RANDOM, n);
				end else begin
					repeat ($urandom_range(1, 6)) queue_byte($urandom_range(0, 255), 1'b0);
				end
			end
			queue_byte(BYTE_PARK, 1'b1); // leave the parser idle before the next setting
			wait_drained();
		end

		if (mismatches == 0) $display("imu_frame_scale_bias_core: match");
		else $display("imu_frame_scale_bias_core: mismatch");
		$finish;
	end

endmodule
